// ----- hdl/ecif_pkg.sv -----
// Package for the embedded controller host interface.
// Holds the command/status structs between controller and datapath, and fixed codes.
// No dependencies.
`timescale 1ns / 1ps

package ecif_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE = 1'b1;

  localparam logic [BYTE_W-1:0] READ_CODE_RESET  = 8'h80;
  localparam logic [BYTE_W-1:0] WRITE_CODE_RESET = 8'h81;

  localparam logic PORT_DATA  = 1'b0;
  localparam logic PORT_CMD   = 1'b1;
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam int unsigned STATUS_OBF_BIT = 0;
  localparam int unsigned STATUS_IBF_BIT = 1;
  localparam int unsigned STATUS_CMD_BIT = 3;

  typedef struct packed {
    logic accept;
    logic start_read;
    logic load_buf;
    logic store_wr;
    logic latch_addr;
    logic set_full;
    logic clr_full;
    logic set_cmd;
    logic clr_cmd;
    logic sel_status;
    logic sel_buffer;
    logic consumed;
  } ecif_cmd_t;

  typedef struct packed {
    logic read_hit;
    logic write_hit;
    logic out_valid;
  } ecif_sts_t;

endpackage

// ----- hdl/ecif_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ecif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ecif_ctrl.sv -----
// Controller for the embedded controller host interface: transaction phase and handshake.
// Depends on ecif_pkg; drives ecif_cmd_t to the datapath, reads ecif_sts_t back.
`timescale 1ns / 1ps

module ecif_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              port_select,
  input  logic              mode,
  input  logic              out_stall,
  input  ecif_pkg::ecif_sts_t sts,
  output ecif_pkg::ecif_cmd_t cmd
);
  import ecif_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_ADDR,
    ST_WRITE_ADDR,
    ST_WRITE_DATA,
    ST_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state == ST_LOAD) || (sts.out_valid && out_stall);
    cmd.accept = in_valid && !in_stall;

    if (state == ST_LOAD) begin
      cmd.load_buf = 1'b1;
      state_next   = ST_IDLE;
    end

    if (cmd.accept) begin
      priority if (mode == MODE_READ) begin
        if (port_select == PORT_CMD) begin
          cmd.sel_status = 1'b1;
        end else begin
          cmd.sel_buffer = 1'b1;
          cmd.clr_full   = 1'b1;
        end
      end else if (port_select == PORT_CMD) begin
        cmd.set_cmd = 1'b1;
        priority if (sts.read_hit) begin
          state_next   = ST_READ_ADDR;
          cmd.consumed = 1'b1;
        end else if (sts.write_hit) begin
          state_next   = ST_WRITE_ADDR;
          cmd.consumed = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end else begin
        cmd.clr_cmd = 1'b1;
        unique case (state)
          ST_READ_ADDR: begin
            cmd.start_read = 1'b1;
            cmd.latch_addr = 1'b1;
            cmd.set_full   = 1'b1;
            cmd.consumed   = 1'b1;
            state_next     = ST_LOAD;
          end
          ST_WRITE_ADDR: begin
            cmd.latch_addr = 1'b1;
            cmd.consumed   = 1'b1;
            state_next     = ST_WRITE_DATA;
          end
          ST_WRITE_DATA: begin
            cmd.store_wr = 1'b1;
            cmd.consumed = 1'b1;
            state_next   = ST_IDLE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/ecif_datapath.sv -----
// Datapath for the embedded controller host interface: command codes, address latch,
// output buffer, status flags, byte store with valid bits, and result register.
// Depends on ecif_pkg and ecif_ram.
`timescale 1ns / 1ps

module ecif_datapath #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ecif_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecif_pkg::BYTE_W-1:0]          cfg_data,
  input  logic [ecif_pkg::BYTE_W-1:0]          write_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [ecif_pkg::BYTE_W-1:0]          read_data,
  output logic                                 consumed,
  input  ecif_pkg::ecif_cmd_t                  cmd,
  output ecif_pkg::ecif_sts_t                  sts
);
  import ecif_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [BYTE_W:0] DEPTH_LIMIT = (BYTE_W + 1)'(STORE_DEPTH);

  logic [BYTE_W-1:0]      read_code;
  logic [BYTE_W-1:0]      write_code;
  logic [BYTE_W-1:0]      address_latch;
  logic [BYTE_W-1:0]      output_buffer;
  logic                   output_full;
  logic                   last_was_command;
  logic [STORE_DEPTH-1:0] valid;
  logic                   rd_ok;
  logic                   rd_hit;
  logic                   wr_ok;
  logic                   ram_we;
  logic [BYTE_W-1:0]      ram_rdata;
  logic [BYTE_W-1:0]      status_byte;
  logic [BYTE_W-1:0]      rdata_next;

  assign sts.read_hit  = (write_data == read_code);
  assign sts.write_hit = (write_data == write_code);
  assign sts.out_valid = out_valid;

  assign rd_hit = ({1'b0, write_data} < DEPTH_LIMIT) && valid[write_data[AW-1:0]];
  assign wr_ok  = ({1'b0, address_latch} < DEPTH_LIMIT);
  assign ram_we = cmd.store_wr && wr_ok;

  ecif_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(address_latch[AW-1:0]),
    .wdata(write_data),
    .raddr(write_data[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    status_byte                 = '0;
    status_byte[STATUS_CMD_BIT] = last_was_command;
    status_byte[STATUS_IBF_BIT] = 1'b0;
    status_byte[STATUS_OBF_BIT] = output_full;
    priority if (cmd.sel_status) begin
      rdata_next = status_byte;
    end else if (cmd.sel_buffer) begin
      rdata_next = output_buffer;
    end else begin
      rdata_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= rd_hit;
    if (cmd.latch_addr) begin
      address_latch <= write_data;
    end
    if (cmd.load_buf) begin
      output_buffer <= rd_ok ? ram_rdata : '0;
    end
    if (cmd.accept) begin
      read_data <= rdata_next;
      consumed  <= cmd.consumed;
    end
    if (rst) begin
      read_code        <= READ_CODE_RESET;
      write_code       <= WRITE_CODE_RESET;
      output_full      <= 1'b0;
      last_was_command <= 1'b0;
      valid            <= '0;
      out_valid        <= 1'b0;
      address_latch    <= '0;
      output_buffer    <= '0;
    end else begin
      if (cfg_we) begin
        priority if (cfg_index == CFG_READ_CODE) begin
          read_code <= cfg_data;
        end else if (cfg_index == CFG_WRITE_CODE) begin
          write_code <= cfg_data;
        end
      end
      if (cmd.set_full) begin
        output_full <= 1'b1;
      end else if (cmd.clr_full) begin
        output_full <= 1'b0;
      end
      if (cmd.set_cmd) begin
        last_was_command <= 1'b1;
      end else if (cmd.clr_cmd) begin
        last_was_command <= 1'b0;
      end
      if (ram_we) begin
        valid[address_latch[AW-1:0]] <= 1'b1;
      end
      if (cmd.accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/acpi_ec_host_interface_top.sv -----
// Embedded controller host interface, device side: top level.
// Output: a word's result is in the output register in the cycle after it is accepted.
// Throughput: one word per cycle while the output is not stalled; a data write that
// completes a read command stalls the input while the byte store is read into the output buffer.
// Reset: synchronous; clears flags, phase, buffer and every store valid bit at once.
// Depends on ecif_pkg, ecif_ctrl, ecif_datapath, ecif_ram.
`timescale 1ns / 1ps

module acpi_ec_host_interface_top #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ecif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecif_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           port_select,
  input  logic                           mode,
  input  logic [ecif_pkg::BYTE_W-1:0]    write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ecif_pkg::BYTE_W-1:0]    read_data,
  output logic                           consumed
);
  import ecif_pkg::*;

  ecif_cmd_t cmd;
  ecif_sts_t sts;

  ecif_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .port_select(port_select),
    .mode       (mode),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ecif_datapath #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .write_data(write_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .read_data (read_data),
    .consumed  (consumed),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  a_load_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.start_read |=> cmd.load_buf)
    else $error("store read not followed by buffer load");

  a_load_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.load_buf |-> in_stall)
    else $error("input accepted during buffer load");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> out_valid)
    else $error("accepted word produced no result");

  a_read_sets_no_consume: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && mode == MODE_READ) |=> (out_valid && !consumed))
    else $error("read access reported as consumed");
`endif

endmodule

// ----- sim/tb_acpi_ec_host_interface_top.sv -----
// Self-checking testbench for the embedded controller host interface top level.
// Drives directed and random host port accesses and checks every result word.
// Depends on ecif_pkg and acpi_ec_host_interface_top.
`timescale 1ns / 1ps

module tb_acpi_ec_host_interface_top;
  import ecif_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned MAX_SHOWN = 40;
  localparam logic [BYTE_W-1:0] QUERY_CMD = 8'h84;
  localparam int unsigned NUM_SETTINGS = 5;
  localparam int unsigned ITEMS_PER_SETTING = 400;

  typedef enum logic [1:0] {
    EC_IDLE,
    EC_READ_ADDR,
    EC_WRITE_ADDR,
    EC_WRITE_DATA
  } ec_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd;
    logic              cons;
  } ec_word_t;

  typedef struct packed {
    logic              ps;
    logic              md;
    logic [BYTE_W-1:0] wd;
    logic              fixed;
    logic [BYTE_W-1:0] rd;
    logic              cons;
  } access_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              port_select;
  logic              mode;
  logic [BYTE_W-1:0] write_data;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] read_data;
  logic              consumed;

  acpi_ec_host_interface_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .port_select(port_select),
    .mode       (mode),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .consumed   (consumed)
  );

  // host-visible state of the controller as predicted
  logic [BYTE_W-1:0] ec_store [0:255];
  ec_phase_t         ec_phase;
  logic [BYTE_W-1:0] ec_addr;
  logic [BYTE_W-1:0] ec_obuf;
  logic              ec_obf;
  logic              ec_cmd_flag;
  logic [BYTE_W-1:0] rd_code;
  logic [BYTE_W-1:0] wr_code;

  ec_word_t expected_words [$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned accesses_sent = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  access_row_t directed_rows [25] = '{
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h00, 1'b0},
    '{PORT_DATA, MODE_READ,  8'hFF,            1'b1, 8'h00, 1'b0},
    '{PORT_DATA, MODE_WRITE, 8'hFF,            1'b1, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_WRITE, WRITE_CODE_RESET, 1'b1, 8'h00, 1'b1},
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h08, 1'b0},
    '{PORT_DATA, MODE_WRITE, 8'hFF,            1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'hA5,            1'b1, 8'h00, 1'b1},
    '{PORT_CMD,  MODE_WRITE, READ_CODE_RESET,  1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'hFF,            1'b1, 8'h00, 1'b1},
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h01, 1'b0},
    '{PORT_DATA, MODE_READ,  8'h00,            1'b0, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h00, 1'b0},
    '{PORT_DATA, MODE_READ,  8'h00,            1'b0, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_WRITE, QUERY_CMD,        1'b1, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_READ,  8'h00,            1'b1, 8'h08, 1'b0},
    '{PORT_DATA, MODE_WRITE, 8'h00,            1'b1, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_WRITE, WRITE_CODE_RESET, 1'b1, 8'h00, 1'b1},
    '{PORT_CMD,  MODE_WRITE, READ_CODE_RESET,  1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'h00,            1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_READ,  8'h00,            1'b0, 8'h00, 1'b0},
    '{PORT_CMD,  MODE_WRITE, WRITE_CODE_RESET, 1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'h00,            1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'h5A,            1'b1, 8'h00, 1'b1},
    '{PORT_DATA, MODE_WRITE, 8'hFF,            1'b1, 8'h00, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic predict_access(input logic ps, input logic md, input logic [BYTE_W-1:0] wd);
    ec_word_t w;
    w = '0;
    if (md == MODE_READ) begin
      if (ps == PORT_CMD) begin
        w.rd[STATUS_CMD_BIT] = ec_cmd_flag;
        w.rd[STATUS_OBF_BIT] = ec_obf;
      end else begin
        w.rd = ec_obuf;
        ec_obf = 1'b0;
      end
    end else if (ps == PORT_CMD) begin
      ec_cmd_flag = 1'b1;
      if (wd == rd_code) begin
        ec_phase = EC_READ_ADDR;
        w.cons = 1'b1;
      end else if (wd == wr_code) begin
        ec_phase = EC_WRITE_ADDR;
        w.cons = 1'b1;
      end else begin
        ec_phase = EC_IDLE;
      end
    end else begin
      ec_cmd_flag = 1'b0;
      case (ec_phase)
        EC_READ_ADDR: begin
          ec_addr = wd;
          ec_obuf = (int'(wd) < STORE_DEPTH) ? ec_store[wd] : '0;
          ec_obf = 1'b1;
          ec_phase = EC_IDLE;
          w.cons = 1'b1;
        end
        EC_WRITE_ADDR: begin
          ec_addr = wd;
          ec_phase = EC_WRITE_DATA;
          w.cons = 1'b1;
        end
        EC_WRITE_DATA: begin
          if (int'(ec_addr) < STORE_DEPTH) ec_store[ec_addr] = wd;
          ec_phase = EC_IDLE;
          w.cons = 1'b1;
        end
        default: begin
        end
      endcase
    end
    expected_words.push_back(w);
  endtask

  // call right after a rising edge; returns right after the accepting edge
  task automatic send_word(input logic ps, input logic md, input logic [BYTE_W-1:0] wd);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    port_select <= ps;
    mode <= md;
    write_data <= wd;
    do @(posedge clk); while (in_stall);
    predict_access(ps, md, wd);
    accesses_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_codes(input logic [BYTE_W-1:0] rc, input logic [BYTE_W-1:0] wc);
    cfg_we <= 1'b1;
    cfg_index <= CFG_READ_CODE;
    cfg_data <= rc;
    @(posedge clk);
    rd_code = rc;
    cfg_index <= CFG_WRITE_CODE;
    cfg_data <= wc;
    @(posedge clk);
    wr_code = wc;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_address();
    return ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(0, 15))
                                       : BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned setting);
    int unsigned sent;
    int unsigned kind;
    logic [BYTE_W-1:0] b;
    bit held;
    bit paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < n) begin
      if (sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      // hold the receiver off while the sender keeps offering
      if (setting == 1 && sent >= 40 && !held) begin
        long_hold_req = 1'b1;
        held = 1'b1;
      end
      // pause the sender until every result is back
      if (setting == 2 && sent >= 200 && !paused) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait (expected_words.size() == 0);
        @(posedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_word(PORT_CMD, MODE_WRITE, rd_code);
        send_word(PORT_DATA, MODE_WRITE, pick_address());
        sent += 2;
        if ($urandom_range(0, 1) == 0) begin
          send_word(PORT_CMD, MODE_READ, BYTE_W'($urandom));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_word(PORT_DATA, MODE_READ, BYTE_W'($urandom));
          sent++;
        end
      end else if (kind < 75) begin
        send_word(PORT_CMD, MODE_WRITE, wr_code);
        send_word(PORT_DATA, MODE_WRITE, pick_address());
        send_word(PORT_DATA, MODE_WRITE, BYTE_W'($urandom));
        sent += 3;
      end else begin
        case ($urandom_range(0, 3))
          0: b = rd_code;
          1: b = wr_code;
          default: b = BYTE_W'($urandom);
        endcase
        send_word(1'($urandom), 1'($urandom), b);
        sent++;
      end
    end
  endtask

  task automatic check_word(input logic [BYTE_W-1:0] rd, input logic cons);
    ec_word_t w;
    words_checked++;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: unexpected word read_data %02h consumed %0b", $time, rd, cons);
    end else begin
      w = expected_words.pop_front();
      if (rd !== w.rd) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: read_data expected %02h got %02h", $time, w.rd, rd);
      end
      if (cons !== w.cons) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: consumed expected %0b got %0b", $time, w.cons, cons);
      end
    end
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_word(read_data, consumed);
        hold_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("FAIL acpi_ec_host_interface_top");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] rc;
    logic [BYTE_W-1:0] wc;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    port_select <= PORT_DATA;
    mode <= MODE_READ;
    write_data <= '0;
    for (int i = 0; i < 256; i++) ec_store[i] = '0;
    ec_phase = EC_IDLE;
    ec_addr = '0;
    ec_obuf = '0;
    ec_obf = 1'b0;
    ec_cmd_flag = 1'b0;
    rd_code = READ_CODE_RESET;
    wr_code = WRITE_CODE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].ps, directed_rows[i].md, directed_rows[i].wd);
      if (directed_rows[i].fixed)
        expected_words[expected_words.size() - 1] = '{directed_rows[i].rd,
                                                       directed_rows[i].cons};
    end
    drain_results();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin rc = 8'h00; wc = 8'hFF; end
        1: begin rc = 8'hFF; wc = 8'h00; end
        2: begin rc = 8'h5A; wc = 8'h5A; end
        3: begin rc = BYTE_W'($urandom); wc = BYTE_W'($urandom); end
        default: begin rc = READ_CODE_RESET; wc = WRITE_CODE_RESET; end
      endcase
      write_codes(rc, wc);
      run_random(ITEMS_PER_SETTING, s);
      drain_results();
    end

    $display("Ran %0d host accesses (%0d directed) across %0d command code settings,",
             accesses_sent, $size(directed_rows), NUM_SETTINGS);
    $display("including extreme and equal codes; %0d result words checked, %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS acpi_ec_host_interface_top");
    end else begin
      $display("FAIL acpi_ec_host_interface_top");
    end
    $finish;
  end

endmodule
